// ===== hdl/mrm_pkg.sv =====
`timescale 1ns / 1ps

package mrm_pkg;

    // defaults for the top-level parameters
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // 4x4 matrix: rows, columns and cells in the chain
    localparam int DIM   = 4;
    localparam int ROW_W = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } t_op;

    // control travelling with each word down the chain
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [ROW_W-1:0] row;
    } t_ctl;

endpackage

// ===== hdl/mrm_cell.sv =====
`timescale 1ns / 1ps

module mrm_cell #(
    parameter int CELL_IDX   = 0,
    parameter int FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  mrm_pkg::t_ctl                        i_ctl,
    input  logic signed [ELEM_WIDTH-1:0]         i_elem [mrm_pkg::DIM],
    input  logic signed [2*ELEM_WIDTH+2:0]       i_psum [mrm_pkg::DIM],
    output mrm_pkg::t_ctl                        o_ctl,
    output logic signed [ELEM_WIDTH-1:0]         o_elem [mrm_pkg::DIM],
    output logic signed [2*ELEM_WIDTH+2:0]       o_psum [mrm_pkg::DIM]
);
    import mrm_pkg::*;

    localparam int PW  = 2 * ELEM_WIDTH;
    localparam int AW  = 2 * ELEM_WIDTH + 3;
    localparam int HSH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic signed [PW:0] HALF =
        (FRAC_BITS == 0) ? '0 : ((PW+1)'(1) << HSH);

    // this cell's row of B
    logic signed [ELEM_WIDTH-1:0] r_brow [DIM];

    // stage 1: products
    t_ctl                         r_ctl1;
    logic signed [ELEM_WIDTH-1:0] r_elem1 [DIM];
    logic signed [AW-1:0]         r_psum1 [DIM];
    logic signed [PW-1:0]         r_prod  [DIM];

    // stage 2: rounded and accumulated
    t_ctl                         r_ctl2;
    logic signed [ELEM_WIDTH-1:0] r_elem2 [DIM];
    logic signed [AW-1:0]         r_sum2  [DIM];

    logic signed [ELEM_WIDTH-1:0] w_a;
    logic                         w_load;
    logic signed [PW:0]           w_rnd_t [DIM];
    logic signed [PW:0]           w_rnd   [DIM];
    logic signed [AW-1:0]         n_sum   [DIM];

    assign w_a    = i_elem[CELL_IDX];
    assign w_load = i_en && i_ctl.valid && (i_ctl.op == OP_LOAD) &&
                    (i_ctl.row == ROW_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int j = 0; j < DIM; j++) r_brow[j] <= i_elem[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIM; j++) begin
                r_elem1[j] <= i_elem[j];
                r_psum1[j] <= i_psum[j];
                r_prod[j]  <= PW'(w_a) * PW'(r_brow[j]);
            end
        end
    end

    // round to nearest at the binary point, ties upward
    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            w_rnd_t[j] = (PW+1)'(r_prod[j]) + HALF;
            w_rnd[j]   = w_rnd_t[j] >>> FRAC_BITS;
            n_sum[j]   = r_psum1[j] + AW'(w_rnd[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIM; j++) begin
                r_elem2[j] <= r_elem1[j];
                r_sum2[j]  <= n_sum[j];
            end
        end
    end

    assign o_ctl  = r_ctl2;
    assign o_elem = r_elem2;
    assign o_psum = r_sum2;

endmodule

// ===== hdl/mrm_sat.sv =====
`timescale 1ns / 1ps

module mrm_sat #(
    parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  mrm_pkg::t_ctl                    i_ctl,
    input  logic signed [2*ELEM_WIDTH+2:0]   i_sum [mrm_pkg::DIM],
    output logic                             o_valid,
    output logic [mrm_pkg::ROW_W-1:0]        o_row,
    output logic signed [ELEM_WIDTH-1:0]     o_prod [mrm_pkg::DIM],
    output logic                             o_saturated
);
    import mrm_pkg::*;

    localparam int AW = 2 * ELEM_WIDTH + 3;
    localparam int TW = AW - ELEM_WIDTH + 1;   // bits that must all match
    localparam logic signed [ELEM_WIDTH-1:0] MAXV = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ELEM_WIDTH-1:0] MINV = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic                         r_valid;
    logic [ROW_W-1:0]             r_row;
    logic signed [ELEM_WIDTH-1:0] r_prod [DIM];
    logic                         r_sat;

    logic [TW-1:0]                w_top  [DIM];
    logic [DIM-1:0]               w_clip;
    logic signed [ELEM_WIDTH-1:0] n_prod [DIM];

    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            w_top[j]  = i_sum[j][AW-1:ELEM_WIDTH-1];
            w_clip[j] = (w_top[j] != '0) && (w_top[j] != '1);
            if (!w_clip[j]) begin
                n_prod[j] = i_sum[j][ELEM_WIDTH-1:0];
            end else if (i_sum[j][AW-1]) begin
                n_prod[j] = MINV;
            end else begin
                n_prod[j] = MAXV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid && (i_ctl.op == OP_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row  <= i_ctl.row;
            r_prod <= n_prod;
            r_sat  <= |w_clip;
        end
    end

    assign o_valid     = r_valid;
    assign o_row       = r_row;
    assign o_prod      = r_prod;
    assign o_saturated = r_sat;

endmodule

// ===== hdl/matrix4x4_row_multiply.sv =====
`timescale 1ns / 1ps
// Path: a product word passes two register stages in each of four cells, then
//   the saturation register, before it is valid at the output.
// Throughput: one word per cycle while not stalled, loads and multiplies alike; a stall on the
//   output freezes the whole chain, so o_stall follows i_stall when o_valid.
// Reset: synchronous, active low; clears the valid bits of the chain only.
//   Stored matrix B is undefined until each row has been loaded.

module matrix4x4_row_multiply #(
    parameter int FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [mrm_pkg::ROW_W-1:0]     i_row_index,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem0,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem1,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem2,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem3,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mrm_pkg::ROW_W-1:0]     o_out_row,
    output logic signed [ELEM_WIDTH-1:0]  o_prod0,
    output logic signed [ELEM_WIDTH-1:0]  o_prod1,
    output logic signed [ELEM_WIDTH-1:0]  o_prod2,
    output logic signed [ELEM_WIDTH-1:0]  o_prod3,
    output logic                          o_saturated
);
    import mrm_pkg::*;

    localparam int AW = 2 * ELEM_WIDTH + 3;

    // Chain of four cells: cell k holds row k of B and adds a[k]*B[k][j]
    // into the running column sums. Load words run down the same chain, so
    // each cell updates its row in order with the multiply words around it.
    t_ctl                         w_ctl  [DIM+1];
    logic signed [ELEM_WIDTH-1:0] w_elem [DIM+1][DIM];
    logic signed [AW-1:0]         w_psum [DIM+1][DIM];
    logic signed [ELEM_WIDTH-1:0] w_prod [DIM];

    logic w_en;

    // whole chain advances unless the output word is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // head of the chain: the input word, sums start at zero
    always_comb begin
        w_ctl[0].valid = i_valid;
        w_ctl[0].op    = t_op'(i_operation);
        w_ctl[0].row   = i_row_index;
        w_elem[0][0]   = i_elem0;
        w_elem[0][1]   = i_elem1;
        w_elem[0][2]   = i_elem2;
        w_elem[0][3]   = i_elem3;
        for (int j = 0; j < DIM; j++) w_psum[0][j] = '0;
    end

    for (genvar k = 0; k < DIM; k++) begin : g_cell
        mrm_cell #(
            .CELL_IDX   (k),
            .FRAC_BITS  (FRAC_BITS),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_elem  (w_elem[k]),
            .i_psum  (w_psum[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_elem  (w_elem[k+1]),
            .o_psum  (w_psum[k+1])
        );
    end

    // tail: clip sums to element width, hold the product word
    mrm_sat #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (w_ctl[DIM]),
        .i_sum       (w_psum[DIM]),
        .o_valid     (o_valid),
        .o_row       (o_out_row),
        .o_prod      (w_prod),
        .o_saturated (o_saturated)
    );

    assign o_prod0 = w_prod[0];
    assign o_prod1 = w_prod[1];
    assign o_prod2 = w_prod[2];
    assign o_prod3 = w_prod[3];

    // back-pressure only ever comes from a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output word");

    // a load word reaching the tail never shows up as a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_ctl[DIM].valid && (w_ctl[DIM].op == OP_LOAD)) |=> !o_valid)
        else $error("load word produced a result");

    // chain frozen while stalled
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_ctl[DIM]) && $stable(w_ctl[1]))
        else $error("chain moved during a stall");

endmodule
